>>> design/tcw_pkg.sv
package tcw_pkg;

    // Operation codes carried in s_tuser
    typedef enum logic [1:0] {
        OP_PUT_CHAR   = 2'd0,
        OP_SET_CURSOR = 2'd1,
        OP_CLEAR      = 2'd2,
        OP_READ_CELL  = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCROLL_COPY,
        ST_SCROLL_BLANK,
        ST_PUT,
        ST_CLEAR,
        ST_FINISH
    } state_t;

    // One screen cell: attribute in the high byte, character in the low byte
    typedef struct packed {
        logic [7:0] color;
        logic [7:0] ch;
    } cell_t;

    localparam int OPCODE_W  = 2;
    localparam int CHAR_W    = 8;
    localparam int ROW_IN_W  = 5;
    localparam int COL_IN_W  = 7;
    localparam int COLOR_W   = 8;
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 32;

    localparam logic [CHAR_W-1:0]  CHAR_NEWLINE   = 8'h0A;
    localparam logic [CHAR_W-1:0]  CHAR_RETURN    = 8'h0D;
    localparam logic [CHAR_W-1:0]  CHAR_BACKSPACE = 8'h08;
    localparam logic [CHAR_W-1:0]  CHAR_SPACE     = 8'h20;
    localparam logic [CHAR_W-1:0]  CHAR_BLANK     = 8'h00;
    localparam logic [COLOR_W-1:0] COLOR_RESET    = 8'h0F;

endpackage

>>> design/tcw_screen_ram.sv
module tcw_screen_ram #(
    parameter int DEPTH = 2000,
    parameter int AW    = 11
) (
    input  logic            aclk,
    input  logic            we,
    input  logic [AW-1:0]   waddr,
    input  tcw_pkg::cell_t  wdata,
    input  logic            re,
    input  logic [AW-1:0]   raddr,
    output tcw_pkg::cell_t  rdata
);
    import tcw_pkg::*;

    cell_t mem [DEPTH];
    cell_t rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read; hold data when not reading
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> design/text_console_writer.sv
// Text console writer: a teletype-style writer into a screen store of
// SCREEN_ROWS x SCREEN_COLS cells (character plus attribute byte).
//
// Channels: requests enter on s_tvalid/s_tready; the opcode rides on
// s_tuser, the character and position on s_tdata. One result per request
// leaves on m_tvalid/m_tready: the cursor after the operation and, for a
// cell read, the cell contents (zero otherwise). The attribute byte is
// written through cfg_valid/cfg_ready/cfg_data, which is always ready.
//
// Sequencing: one request at a time; the console takes the next request
// no earlier than the cycle after the result loads. The screen memory, one
// read and one write per cycle, paces the long operations: a scroll copies
// one cell per cycle and then blanks the bottom row one cell per cycle; a
// clear writes one cell per cycle.
// Reset clears the cursor to the origin and the attribute to 0x0F. The
// screen store is not cleared; issue a clear before reading cells. When
// the receiver stalls, the result is held in the output register and the
// next request is still accepted; it finishes once the register drains.
module text_console_writer #(
    parameter int SCREEN_COLS = 80,
    parameter int SCREEN_ROWS = 25
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // request channel
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // s_tdata: char_code[7:0], row_in[12:8], col_in[19:13], zero pad
    input  logic [tcw_pkg::S_TDATA_W-1:0]    s_tdata,
    // s_tuser: opcode[1:0]
    input  logic [tcw_pkg::OPCODE_W-1:0]     s_tuser,
    // result channel
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // m_tdata: cursor_row_out[4:0], cursor_col_out[11:5], cell_char[19:12],
    //          cell_color[27:20], zero pad
    output logic [tcw_pkg::M_TDATA_W-1:0]    m_tdata,
    // attribute register write
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [tcw_pkg::COLOR_W-1:0]      cfg_data
);
    import tcw_pkg::*;

    localparam int RW    = $clog2(SCREEN_ROWS);
    localparam int CW    = $clog2(SCREEN_COLS);
    localparam int CELLS = SCREEN_ROWS * SCREEN_COLS;
    localparam int AW    = $clog2(CELLS);
    localparam int NW    = $clog2(CELLS + 1);

    localparam logic [NW-1:0] CELLS_N       = NW'(CELLS);
    localparam logic [NW-1:0] CELLS_LAST    = NW'(CELLS - 1);
    localparam logic [NW-1:0] COLS_N        = NW'(SCREEN_COLS);
    localparam logic [NW-1:0] LAST_ROW_BASE = NW'((SCREEN_ROWS - 1) * SCREEN_COLS);
    localparam logic [RW-1:0] ROW_LAST      = RW'(SCREEN_ROWS - 1);
    localparam logic [RW-1:0] ROW_SCROLLED  = RW'(SCREEN_ROWS - 2);
    localparam logic [CW-1:0] COL_LAST      = CW'(SCREEN_COLS - 1);

    // Linear cell address of a row and column on the screen
    function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] r,
                                                input logic [CW-1:0] c);
        return AW'(AW'(r) * AW'(SCREEN_COLS)) + AW'(c);
    endfunction

    state_t                 state_reg, state_next;
    logic [NW-1:0]          cnt_reg, cnt_next;
    logic [RW-1:0]          cursor_row_reg, cursor_row_next;
    logic [CW-1:0]          cursor_col_reg, cursor_col_next;
    logic [COLOR_W-1:0]     color_reg, color_next;
    op_t                    op_reg, op_next;
    logic [CHAR_W-1:0]      char_reg, char_next;
    logic                   hit_reg, hit_next;
    logic                   m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0]   m_tdata_reg, m_tdata_next;

    // unpacked request
    op_t                    s_op;
    logic [CHAR_W-1:0]      s_char;
    logic [ROW_IN_W-1:0]    s_row;
    logic [COL_IN_W-1:0]    s_col;
    logic                   s_accept;
    logic                   s_in_range;
    logic                   out_load;

    // put-character helpers
    logic [RW-1:0]          bs_row;
    logic [CW-1:0]          bs_col;
    logic                   col_at_end;

    // memory port
    logic                   ram_we;
    logic [AW-1:0]          ram_waddr;
    cell_t                  ram_wdata;
    logic                   ram_re;
    logic [AW-1:0]          ram_raddr;
    cell_t                  ram_rdata;
    cell_t                  cell_res;

    assign s_op       = op_t'(s_tuser);
    assign s_char     = s_tdata[7:0];
    assign s_row      = s_tdata[12:8];
    assign s_col      = s_tdata[19:13];
    assign s_accept   = s_tvalid && s_tready;
    assign s_in_range = (32'(s_row) < SCREEN_ROWS) && (32'(s_col) < SCREEN_COLS);
    assign out_load   = (state_reg == ST_FINISH) && (!m_tvalid_reg || m_tready);

    assign cfg_ready  = 1'b1;
    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;

    tcw_screen_ram #(
        .DEPTH (CELLS),
        .AW    (AW)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Backspace target: step back, wrap to the previous row, stay at origin
    always_comb begin
        bs_row = cursor_row_reg;
        bs_col = cursor_col_reg;
        if (cursor_col_reg == '0) begin
            if (cursor_row_reg != '0) begin
                bs_row = cursor_row_reg - RW'(1);
                bs_col = COL_LAST;
            end
        end else begin
            bs_col = cursor_col_reg - CW'(1);
        end
    end

    assign col_at_end = (cursor_col_reg == COL_LAST);

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    case (s_op)
                        OP_PUT_CHAR: begin
                            state_next = (cursor_row_reg >= ROW_LAST) ? ST_SCROLL_COPY
                                                                      : ST_PUT;
                        end
                        OP_CLEAR:    state_next = ST_CLEAR;
                        default:     state_next = ST_FINISH;
                    endcase
                end
            end
            ST_SCROLL_COPY: begin
                if (cnt_reg == CELLS_N) begin
                    state_next = ST_SCROLL_BLANK;
                end
            end
            ST_SCROLL_BLANK: begin
                if (cnt_reg == CELLS_LAST) begin
                    state_next = ST_PUT;
                end
            end
            ST_PUT: state_next = ST_FINISH;
            ST_CLEAR: begin
                if (cnt_reg == CELLS_LAST) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Datapath and memory control
    always_comb begin
        cnt_next        = cnt_reg;
        cursor_row_next = cursor_row_reg;
        cursor_col_next = cursor_col_reg;
        op_next         = op_reg;
        char_next       = char_reg;
        hit_next        = hit_reg;
        m_tdata_next    = m_tdata_reg;
        s_tready        = 1'b0;
        ram_we          = 1'b0;
        ram_waddr       = '0;
        ram_wdata       = '{color: color_reg, ch: CHAR_BLANK};
        ram_re          = 1'b0;
        ram_raddr       = '0;
        cell_res        = '0;

        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_accept) begin
                    op_next   = s_op;
                    char_next = s_char;
                    hit_next  = 1'b0;
                    case (s_op)
                        OP_PUT_CHAR: cnt_next = COLS_N;
                        OP_SET_CURSOR: begin
                            // saturate to the screen bounds
                            cursor_row_next = (32'(s_row) < SCREEN_ROWS) ? RW'(s_row)
                                                                         : ROW_LAST;
                            cursor_col_next = (32'(s_col) < SCREEN_COLS) ? CW'(s_col)
                                                                         : COL_LAST;
                        end
                        OP_CLEAR:    cnt_next = '0;
                        OP_READ_CELL: begin
                            hit_next  = s_in_range;
                            ram_re    = s_in_range;
                            ram_raddr = cell_addr(RW'(s_row), CW'(s_col));
                        end
                        default: ;
                    endcase
                end
            end
            ST_SCROLL_COPY: begin
                // read cell cnt, write the cell read last cycle one row up
                if (cnt_reg != CELLS_N) begin
                    ram_re    = 1'b1;
                    ram_raddr = AW'(cnt_reg);
                end
                if (cnt_reg != COLS_N) begin
                    ram_we    = 1'b1;
                    ram_waddr = AW'(cnt_reg - COLS_N - NW'(1));
                    ram_wdata = ram_rdata;
                end
                cnt_next = (cnt_reg == CELLS_N) ? LAST_ROW_BASE : NW'(cnt_reg + NW'(1));
            end
            ST_SCROLL_BLANK: begin
                ram_we    = 1'b1;
                ram_waddr = AW'(cnt_reg);
                cnt_next  = NW'(cnt_reg + NW'(1));
                if (cnt_reg == CELLS_LAST) begin
                    cursor_row_next = ROW_SCROLLED;
                end
            end
            ST_PUT: begin
                if (char_reg == CHAR_NEWLINE) begin
                    cursor_row_next = cursor_row_reg + RW'(1);
                    cursor_col_next = '0;
                end else if (char_reg == CHAR_RETURN) begin
                    cursor_col_next = '0;
                end else if (char_reg == CHAR_BACKSPACE) begin
                    cursor_row_next = bs_row;
                    cursor_col_next = bs_col;
                    ram_we          = 1'b1;
                    ram_waddr       = cell_addr(bs_row, bs_col);
                    ram_wdata       = '{color: color_reg, ch: CHAR_SPACE};
                end else begin
                    ram_we    = 1'b1;
                    ram_waddr = cell_addr(cursor_row_reg, cursor_col_reg);
                    ram_wdata = '{color: color_reg, ch: char_reg};
                    if (col_at_end) begin
                        cursor_col_next = '0;
                        cursor_row_next = cursor_row_reg + RW'(1);
                    end else begin
                        cursor_col_next = cursor_col_reg + CW'(1);
                    end
                end
            end
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = AW'(cnt_reg);
                cnt_next  = NW'(cnt_reg + NW'(1));
                if (cnt_reg == CELLS_LAST) begin
                    cursor_row_next = '0;
                    cursor_col_next = '0;
                end
            end
            ST_FINISH: begin
                // read data is still held from the request's read
                if (op_reg == OP_READ_CELL && hit_reg) begin
                    cell_res = ram_rdata;
                end
                if (out_load) begin
                    m_tdata_next = {4'b0, cell_res.color, cell_res.ch,
                                    7'(cursor_col_reg), 5'(cursor_row_reg)};
                end
            end
            default: ;
        endcase
    end

    assign color_next    = cfg_valid ? cfg_data : color_reg;
    assign m_tvalid_next = out_load ? 1'b1 : (m_tready ? 1'b0 : m_tvalid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            cursor_row_reg <= '0;
            cursor_col_reg <= '0;
            color_reg      <= COLOR_RESET;
            m_tvalid_reg   <= 1'b0;
            cnt_reg        <= '0;
        end else begin
            state_reg      <= state_next;
            cursor_row_reg <= cursor_row_next;
            cursor_col_reg <= cursor_col_next;
            color_reg      <= color_next;
            m_tvalid_reg   <= m_tvalid_next;
            cnt_reg        <= cnt_next;
        end
    end

    // payload: no reset needed
    always_ff @(posedge aclk) begin
        op_reg      <= op_next;
        char_reg    <= char_next;
        hit_reg     <= hit_next;
        m_tdata_reg <= m_tdata_next;
    end

endmodule

>>> design/tcw_checker.sv
module tcw_checker #(
    parameter int SCREEN_COLS = 80,
    parameter int SCREEN_ROWS = 25
) (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [tcw_pkg::M_TDATA_W-1:0]  m_tdata
);
    import tcw_pkg::*;

    // one request at a time: ready drops right after an accept
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("request accepted while another was in progress");

    // reported cursor column always lies on the screen
    a_col_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (32'(m_tdata[11:5]) < SCREEN_COLS))
        else $error("cursor column off screen");

    // reported cursor row always lies on the screen
    a_row_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (32'(m_tdata[4:0]) < SCREEN_ROWS))
        else $error("cursor row off screen");

    // padding bits above the result fields stay zero
    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[31:28] == 4'b0))
        else $error("result padding not zero");

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result dropped or changed under stall");

endmodule

bind text_console_writer tcw_checker #(
    .SCREEN_COLS (SCREEN_COLS),
    .SCREEN_ROWS (SCREEN_ROWS)
) u_tcw_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

>>> sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import tcw_pkg::*;

    localparam int COLS         = 80;
    localparam int ROWS         = 25;
    localparam int CELLS        = COLS * ROWS;
    // A scroll is the longest operation and needs no handshake; QUIET_LIMIT
    // must outlast it plus the longest receiver stall.
    localparam int QUIET_LIMIT  = 20000;
    localparam int REPORT_MAX   = 10;
    localparam int RANDOM_BATCH = 75;
    localparam int DRAIN_CYCLES = 20;

    // One request as the sender sees it
    typedef struct {
        op_t                 op;
        logic [CHAR_W-1:0]   ch;
        logic [ROW_IN_W-1:0] row;
        logic [COL_IN_W-1:0] col;
    } console_req_t;

    // m_tdata[27:0] viewed field by field, lowest field last in the struct
    typedef struct packed {
        logic [COLOR_W-1:0]  color;
        logic [CHAR_W-1:0]   ch;
        logic [COL_IN_W-1:0] col;
        logic [ROW_IN_W-1:0] row;
    } console_result_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;
    logic [OPCODE_W-1:0]  s_tuser   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [COLOR_W-1:0]   cfg_data  = '0;

    text_console_writer u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Shadow copy of the console: screen, cursor and attribute byte
    cell_t               screen_mirror [CELLS];
    logic [ROW_IN_W-1:0] mirror_row   = '0;
    logic [COL_IN_W-1:0] mirror_col   = '0;
    logic [COLOR_W-1:0]  mirror_color = COLOR_RESET;

    console_req_t    request_q [$];        // requests waiting for the sender
    console_result_t awaited_results [$];  // predicted results, oldest first

    int requests_shown  = 0;
    int requests_taken  = 0;
    int results_seen    = 0;
    int mismatches      = 0;
    int quiet_cycles    = 0;
    int send_gap        = 0;
    int stall_left      = 0;
    int no_idle_run     = 0;

    console_req_t    shown_req;
    console_req_t    taken_req;
    console_result_t got_result;
    console_result_t want_result;
    logic            progress;

    // Apply one request to the shadow console and return the result it owes.
    function automatic console_result_t predict_console_result(console_req_t req);
        console_result_t res;
        int idx;
        res = '0;
        case (req.op)
            OP_PUT_CHAR: begin
                // A cursor on the bottom row scrolls the screen before anything
                // else; the exposed row is blanked with the current attribute.
                if (mirror_row >= ROWS - 1) begin
                    for (idx = COLS; idx < CELLS; idx++)
                        screen_mirror[idx - COLS] = screen_mirror[idx];
                    for (idx = CELLS - COLS; idx < CELLS; idx++)
                        screen_mirror[idx] = {mirror_color, CHAR_BLANK};
                    mirror_row = ROW_IN_W'(ROWS - 2);
                end
                if (req.ch == CHAR_NEWLINE) begin
                    mirror_row++;
                    mirror_col = '0;
                end else if (req.ch == CHAR_RETURN) begin
                    mirror_col = '0;
                end else if (req.ch == CHAR_BACKSPACE) begin
                    // Step back, wrapping to the previous row; hold at the origin
                    if (mirror_col != 0) begin
                        mirror_col--;
                    end else if (mirror_row != 0) begin
                        mirror_row--;
                        mirror_col = COL_IN_W'(COLS - 1);
                    end
                    screen_mirror[int'(mirror_row) * COLS + int'(mirror_col)] =
                        {mirror_color, CHAR_SPACE};
                end else begin
                    screen_mirror[int'(mirror_row) * COLS + int'(mirror_col)] =
                        {mirror_color, req.ch};
                    mirror_col++;
                    if (mirror_col >= COLS) begin
                        mirror_col = '0;
                        mirror_row++;
                    end
                end
            end
            OP_SET_CURSOR: begin
                // Saturate positions beyond the screen to the last row or column
                mirror_row = (req.row < ROWS) ? req.row : ROW_IN_W'(ROWS - 1);
                mirror_col = (req.col < COLS) ? req.col : COL_IN_W'(COLS - 1);
            end
            OP_CLEAR: begin
                for (idx = 0; idx < CELLS; idx++)
                    screen_mirror[idx] = {mirror_color, CHAR_BLANK};
                mirror_row = '0;
                mirror_col = '0;
            end
            default: begin
                // Out-of-range reads answer zero
                if (req.row < ROWS && req.col < COLS) begin
                    idx = int'(req.row) * COLS + int'(req.col);
                    res.ch    = screen_mirror[idx].ch;
                    res.color = screen_mirror[idx].color;
                end
            end
        endcase
        res.row = mirror_row;
        res.col = mirror_col;
        return res;
    endfunction

    // Idle length for either side: mostly none or short, a few long, and
    // now and then a run of back-to-back traffic.
    function automatic int pick_idle_len();
        int roll;
        if (no_idle_run != 0) begin
            no_idle_run--;
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 5) begin
            no_idle_run = $urandom_range(8, 30);
            return 0;
        end
        if (roll < 45) return 0;
        if (roll < 85) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 12);
        return $urandom_range(30, 90);
    endfunction

    task automatic add_request(input op_t op, input logic [CHAR_W-1:0] ch,
                               input logic [ROW_IN_W-1:0] row,
                               input logic [COL_IN_W-1:0] col);
        console_req_t req;
        req.op  = op;
        req.ch  = ch;
        req.row = row;
        req.col = col;
        request_q.push_back(req);
    endtask

    // Queue a batch of random requests. Most are text: printable runs mixed
    // with line controls, plus cursor jumps toward the bottom rows so that
    // scrolls happen often. Unused fields always carry random bits.
    task automatic add_random_requests(input int count);
        console_req_t req;
        int pick;
        int n;
        for (n = 0; n < count; n++) begin
            req.ch  = CHAR_W'($urandom_range(0, 255));
            req.row = ROW_IN_W'($urandom_range(0, 31));
            req.col = COL_IN_W'($urandom_range(0, 127));
            pick = $urandom_range(0, 99);
            if (pick < 58) begin
                req.op = OP_PUT_CHAR;
                pick = $urandom_range(0, 99);
                if (pick < 14)      req.ch = CHAR_NEWLINE;
                else if (pick < 19) req.ch = CHAR_RETURN;
                else if (pick < 29) req.ch = CHAR_BACKSPACE;
                else if (pick < 60) req.ch = CHAR_W'($urandom_range(8'h20, 8'h7E));
            end else if (pick < 72) begin
                req.op = OP_SET_CURSOR;
                pick = $urandom_range(0, 99);
                if (pick < 35) begin
                    req.row = ROW_IN_W'($urandom_range(ROWS - 3, ROWS - 1));
                    req.col = (pick < 12) ? COL_IN_W'(COLS - 1)
                                          : COL_IN_W'($urandom_range(0, COLS - 1));
                end else if (pick < 85) begin
                    req.row = ROW_IN_W'($urandom_range(0, ROWS - 1));
                    req.col = (pick < 45) ? '0 : COL_IN_W'($urandom_range(0, COLS - 1));
                end
                // else leave the full-range position for saturation
            end else if (pick < 74) begin
                req.op = OP_CLEAR;
            end else begin
                req.op = OP_READ_CELL;
                if ($urandom_range(0, 9) != 0) begin
                    req.row = ROW_IN_W'($urandom_range(0, ROWS - 1));
                    req.col = COL_IN_W'($urandom_range(0, COLS - 1));
                end
            end
            request_q.push_back(req);
        end
    endtask

    // Block until every queued request went out and its result came back.
    task automatic wait_console_idle();
        while (request_q.size() != 0 || s_tvalid || awaited_results.size() != 0)
            @(posedge aclk);
        repeat (2) @(posedge aclk);
    endtask

    // Write the attribute register; only called while the console is idle.
    task automatic write_text_color(input logic [COLOR_W-1:0] value);
        @(negedge aclk);
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!(cfg_valid && cfg_ready));
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Request sender: present the next queued request at the falling edge,
    // hold it until taken, then idle for a random gap.
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            send_gap = 0;
        end else if (s_tvalid && requests_taken != requests_shown) begin
            // hold the current request until the console takes it
        end else if (send_gap == 0 && request_q.size() != 0) begin
            shown_req = request_q.pop_front();
            s_tuser  <= shown_req.op;
            s_tdata  <= {4'b0000, shown_req.col, shown_req.row, shown_req.ch};
            s_tvalid <= 1'b1;
            requests_shown++;
            send_gap = pick_idle_len();
        end else begin
            s_tvalid <= 1'b0;
            if (send_gap != 0) send_gap--;
        end
    end

    // Result receiver: drop m_tready for random stretches.
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            stall_left = 0;
        end else if (stall_left != 0) begin
            m_tready <= 1'b0;
            stall_left--;
        end else begin
            m_tready <= 1'b1;
            if ($urandom_range(0, 99) < 20) stall_left = pick_idle_len();
        end
    end

    // Monitor: sample all handshakes at the rising edge, predict on each
    // request taken, check each result against the oldest prediction, and
    // end the run if nothing moves for too long.
    always @(posedge aclk) begin
        if (!aresetn) begin
            mirror_row   = '0;
            mirror_col   = '0;
            mirror_color = COLOR_RESET;
            quiet_cycles = 0;
        end else begin
            progress = 1'b0;
            if (cfg_valid && cfg_ready) begin
                mirror_color = cfg_data;
                progress = 1'b1;
            end
            if (m_tvalid && m_tready) begin
                progress = 1'b1;
                got_result = m_tdata[27:0];
                if (awaited_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display("result %0d with no request outstanding: row %0d col %0d char %02h color %02h",
                                 results_seen, got_result.row, got_result.col,
                                 got_result.ch, got_result.color);
                end else begin
                    want_result = awaited_results.pop_front();
                    if (got_result.row !== want_result.row || got_result.col !== want_result.col ||
                        got_result.ch !== want_result.ch ||
                        got_result.color !== want_result.color) begin
                        mismatches++;
                        if (mismatches <= REPORT_MAX)
                            $display("result %0d: expected row %0d col %0d char %02h color %02h, got row %0d col %0d char %02h color %02h",
                                     results_seen, want_result.row, want_result.col,
                                     want_result.ch, want_result.color, got_result.row,
                                     got_result.col, got_result.ch, got_result.color);
                    end
                end
                results_seen++;
            end
            if (s_tvalid && s_tready) begin
                progress = 1'b1;
                requests_taken++;
                taken_req.op  = op_t'(s_tuser);
                taken_req.ch  = s_tdata[7:0];
                taken_req.row = s_tdata[12:8];
                taken_req.col = s_tdata[19:13];
                awaited_results.push_back(predict_console_result(taken_req));
            end
            if (progress) quiet_cycles = 0;
            else quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("tb_top failed");
                $finish;
            end
        end
    end

    initial begin
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;

        // Directed part, reset attribute. Clear first: the store holds
        // nothing defined until then, so no read may come before it.
        add_request(OP_CLEAR, 8'hFF, 5'd31, 7'd127);
        add_request(OP_READ_CELL, CHAR_W'($urandom), 5'd0, 7'd0);
        add_request(OP_PUT_CHAR, 8'h41, ROW_IN_W'($urandom), COL_IN_W'($urandom));
        add_request(OP_PUT_CHAR, 8'hFF, ROW_IN_W'($urandom), COL_IN_W'($urandom));
        add_request(OP_PUT_CHAR, 8'h00, ROW_IN_W'($urandom), COL_IN_W'($urandom));
        add_request(OP_READ_CELL, CHAR_W'($urandom), 5'd0, 7'd0);
        add_request(OP_READ_CELL, CHAR_W'($urandom), 5'd0, 7'd2);
        // backspace over the last character, then read the space left behind
        add_request(OP_PUT_CHAR, CHAR_BACKSPACE, ROW_IN_W'($urandom), COL_IN_W'($urandom));
        add_request(OP_READ_CELL, CHAR_W'($urandom), 5'd0, 7'd2);
        // backspace at the origin holds the cursor there
        add_request(OP_SET_CURSOR, CHAR_W'($urandom), 5'd0, 7'd0);
        add_request(OP_PUT_CHAR, CHAR_BACKSPACE, ROW_IN_W'($urandom), COL_IN_W'($urandom));
        add_request(OP_READ_CELL, CHAR_W'($urandom), 5'd0, 7'd0);
        // saturate to the bottom-right corner, then scroll and wrap
        add_request(OP_SET_CURSOR, CHAR_W'($urandom), 5'd31, 7'd127);
        add_request(OP_PUT_CHAR, 8'h5A, ROW_IN_W'($urandom), COL_IN_W'($urandom));
        add_request(OP_READ_CELL, CHAR_W'($urandom), 5'd23, 7'd79);
        add_request(OP_READ_CELL, CHAR_W'($urandom), 5'd24, 7'd0);
        // line controls on the bottom row still scroll first
        add_request(OP_PUT_CHAR, CHAR_NEWLINE, ROW_IN_W'($urandom), COL_IN_W'($urandom));
        add_request(OP_PUT_CHAR, CHAR_RETURN, ROW_IN_W'($urandom), COL_IN_W'($urandom));
        // backspace from column 0 wraps to the end of the previous row
        add_request(OP_SET_CURSOR, CHAR_W'($urandom), 5'd5, 7'd0);
        add_request(OP_PUT_CHAR, CHAR_BACKSPACE, ROW_IN_W'($urandom), COL_IN_W'($urandom));
        add_request(OP_READ_CELL, CHAR_W'($urandom), 5'd4, 7'd79);
        // reads outside the screen answer zero
        add_request(OP_READ_CELL, CHAR_W'($urandom), 5'd25, 7'd0);
        add_request(OP_READ_CELL, CHAR_W'($urandom), 5'd0, 7'd80);
        add_request(OP_READ_CELL, CHAR_W'($urandom), 5'd31, 7'd127);
        wait_console_idle();

        // Random phases, one attribute setting each: both extremes first
        write_text_color(8'h00);
        add_random_requests(RANDOM_BATCH);
        wait_console_idle();

        write_text_color(8'hFF);
        add_random_requests(RANDOM_BATCH);
        wait_console_idle();

        write_text_color(COLOR_W'($urandom_range(0, 255)));
        add_random_requests(RANDOM_BATCH);
        wait_console_idle();

        write_text_color(COLOR_W'($urandom_range(0, 255)));
        add_random_requests(RANDOM_BATCH);
        wait_console_idle();

        // Let any stray result surface before judging the run
        repeat (DRAIN_CYCLES) @(posedge aclk);
        mismatches += awaited_results.size();
        if (mismatches == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule

>>> files.f
design/tcw_pkg.sv
design/tcw_screen_ram.sv
design/text_console_writer.sv
design/tcw_checker.sv
sim/tb_top.sv
